/* src/rle_pair_escape_encoder_macros.svh */
// Assertion macros used by the encoder's result queue.
`ifndef RLE_PAIR_ESCAPE_ENCODER_MACROS_SVH
`define RLE_PAIR_ESCAPE_ENCODER_MACROS_SVH

// Check that cond holds at every rising clock edge outside reset.
`define RPE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Check that cons follows ante, both sampled on the same clock.
`define RPE_ASSERT_IMPLIES(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rpe_pkg.sv */
// Shared types and constants of the run-length pair escape encoder.
package rpe_pkg;

  localparam logic [7:0]  RUN_MAX     = 8'd255;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } res_t;

  // Results made by one input beat, up to two.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic push_t add_res(push_t p, res_t r);
    push_t q;
    q = p;
    if (p.n == 2'd0) begin
      q.r0 = r;
    end else begin
      q.r1 = r;
    end
    q.n = p.n + 2'd1;
    return q;
  endfunction

endpackage

/* src/rpe_core.sv */
// Encoder state and single-pass next-state and result logic.
module rpe_core
  import rpe_pkg::*;
#(
  parameter int OUT_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        fire,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output push_t       push
);

  localparam int CW = (OUT_COUNT_BITS > 16) ? OUT_COUNT_BITS : 16;
  localparam logic [OUT_COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [15:0]               max_output_bytes;
  logic [7:0]                previous_byte, previous_byte_next;
  logic                      previous_valid, previous_valid_next;
  logic                      in_run, in_run_next;
  logic [7:0]                run_count, run_count_next;
  logic [OUT_COUNT_BITS-1:0] bytes_written, bytes_written_next;
  logic                      failed, failed_next;
  logic [7:0]                rc_inc;
  push_t                     p;

  function automatic logic [OUT_COUNT_BITS-1:0] sat_inc(logic [OUT_COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + OUT_COUNT_BITS'(1);
  endfunction

  function automatic logic at_limit(logic [OUT_COUNT_BITS-1:0] v, logic [15:0] lim);
    return CW'(v) >= CW'(lim);
  endfunction

  assign rc_inc = run_count + 8'd1;

  always_comb begin
    previous_byte_next  = previous_byte;
    previous_valid_next = previous_valid;
    in_run_next         = in_run;
    run_count_next      = run_count;
    bytes_written_next  = bytes_written;
    failed_next         = failed;
    p                   = '0;

    if (failed) begin
      // drop the beat; last ends the failed message
      if (in_last) begin
        failed_next = 1'b0;
      end
    end else if (in_run && in_byte == previous_byte) begin
      run_count_next = rc_inc;
      if (rc_inc == RUN_MAX || in_last) begin
        p = add_res(p, '{data: rc_inc, last: in_last, ovf: 1'b0});
        bytes_written_next  = sat_inc(bytes_written);
        in_run_next         = 1'b0;
        run_count_next      = '0;
        previous_valid_next = 1'b0;
        if (in_last) begin
          previous_byte_next = '0;
          bytes_written_next = '0;
        end
      end
    end else begin
      if (in_run) begin
        // close the broken run, then treat the byte afresh
        p = add_res(p, '{data: run_count, last: 1'b0, ovf: 1'b0});
        bytes_written_next  = sat_inc(bytes_written);
        in_run_next         = 1'b0;
        run_count_next      = '0;
        previous_valid_next = 1'b0;
      end
      if (at_limit(bytes_written_next, max_output_bytes)) begin
        p = add_res(p, '{data: 8'd0, last: 1'b1, ovf: 1'b1});
        previous_byte_next  = '0;
        previous_valid_next = 1'b0;
        bytes_written_next  = '0;
        failed_next         = !in_last;
      end else if (previous_valid_next && in_byte == previous_byte) begin
        p = add_res(p, '{data: in_byte, last: 1'b0, ovf: 1'b0});
        bytes_written_next = sat_inc(bytes_written_next);
        if (at_limit(bytes_written_next, max_output_bytes)) begin
          p = add_res(p, '{data: 8'd0, last: 1'b1, ovf: 1'b1});
          previous_byte_next  = '0;
          previous_valid_next = 1'b0;
          bytes_written_next  = '0;
          failed_next         = !in_last;
        end else if (in_last) begin
          p = add_res(p, '{data: 8'd0, last: 1'b1, ovf: 1'b0});
          previous_byte_next  = '0;
          previous_valid_next = 1'b0;
          bytes_written_next  = '0;
        end else begin
          in_run_next    = 1'b1;
          run_count_next = '0;
        end
      end else begin
        p = add_res(p, '{data: in_byte, last: in_last, ovf: 1'b0});
        bytes_written_next = sat_inc(bytes_written_next);
        if (in_last) begin
          previous_byte_next  = '0;
          previous_valid_next = 1'b0;
          bytes_written_next  = '0;
        end else begin
          previous_byte_next  = in_byte;
          previous_valid_next = 1'b1;
        end
      end
    end
  end

  assign push = fire ? p : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_bytes <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      max_output_bytes <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte  <= '0;
      previous_valid <= 1'b0;
      in_run         <= 1'b0;
      run_count      <= '0;
      bytes_written  <= '0;
      failed         <= 1'b0;
    end else if (fire) begin
      previous_byte  <= previous_byte_next;
      previous_valid <= previous_valid_next;
      in_run         <= in_run_next;
      run_count      <= run_count_next;
      bytes_written  <= bytes_written_next;
      failed         <= failed_next;
    end
  end

endmodule

/* src/rpe_result_queue.sv */
// Two-entry result queue between the encoder logic and the output channel.
`include "rle_pair_escape_encoder_macros.svh"
module rpe_result_queue
  import rpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       can_accept,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       overflow
);

  res_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  // an input beat may push two results, so room must be certain
  assign can_accept = (count == 2'd0) || (count == 2'd1 && pop);

  assign out_byte = mem[rd_ptr].data;
  assign out_last = mem[rd_ptr].last;
  assign overflow = mem[rd_ptr].ovf;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[!wr_ptr] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr ^ push.n[0];
      rd_ptr <= rd_ptr ^ pop;
      count  <= count + push.n - {1'b0, pop};
    end
  end

  `RPE_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= 2'd2, "result queue overfilled")
  `RPE_ASSERT_ALWAYS(a_push_room, clk, rst, push.n == 2'd0 || can_accept, "push without room")
  `RPE_ASSERT_IMPLIES(a_reset_empty, clk, rst, count == 2'd0 && !out_valid, "queue not empty after reset")

endmodule

/* src/rle_pair_escape_encoder.sv */
// Top level of the run-length pair escape encoder.
// The first result of an input beat is offered in the cycle after the beat is accepted.
// One input beat per cycle while each beat makes one result and out_stall is low.
// A beat that makes two results (closed run plus byte or overflow, or a repeated
// byte plus end marker or overflow) holds input while the two-entry result queue drains.
// Synchronous reset clears message state, empties the queue, limit to 65535.
module rle_pair_escape_encoder
  import rpe_pkg::*;
#(
  parameter int OUT_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        overflow
);

  push_t push;
  logic  can_accept;
  logic  fire;

  assign in_stall = !can_accept;
  assign fire     = in_valid && can_accept;

  rpe_core #(
    .OUT_COUNT_BITS(OUT_COUNT_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .fire           (fire),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .push           (push)
  );

  rpe_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .can_accept (can_accept),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .overflow   (overflow)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the run-length pair escape encoder.
module tb;
  import rpe_pkg::*;

  localparam int          QUIET_LIMIT  = 2000;
  localparam int          RANDOM_BEATS = 480;
  localparam int          DRAIN_HOLD   = 3;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write_en;
  logic [15:0] cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        overflow;

  bit tx_gaps;
  bit rx_gaps;
  int mismatches;
  int useful_beats;
  int quiet_cycles;
  int stall_left;

  // Encoder state as predicted from the accepted beats
  logic [15:0] byte_limit;
  logic [7:0]  hist_byte;
  logic        hist_valid;
  logic        counting;
  logic [7:0]  run_len;
  logic [15:0] out_count;
  logic        dropping;
  res_t        pending_codes[$];

  rle_pair_escape_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .overflow      (overflow)
  );

  initial forever #2 clk = ~clk;

  function automatic void clear_message();
    hist_byte  = '0;
    hist_valid = 1'b0;
    counting   = 1'b0;
    run_len    = '0;
    out_count  = '0;
    dropping   = 1'b0;
  endfunction

  function automatic void expect_code(logic [7:0] b, logic l, logic ovf);
    res_t r;
    r.data = b;
    r.last = l;
    r.ovf  = ovf;
    pending_codes.push_back(r);
  endfunction

  function automatic void count_byte();
    if (out_count != COUNT_MAX) begin
      out_count = out_count + 16'd1;
    end
  endfunction

  function automatic void flag_overflow(logic l);
    expect_code(8'd0, 1'b1, 1'b1);
    clear_message();
    dropping = !l;
  endfunction

  // Returns 1 when the beat is swallowed by a failed message.
  function automatic bit encode_byte(logic [7:0] b, logic l);
    if (dropping) begin
      if (l) begin
        clear_message();
      end
      return 1'b1;
    end
    if (counting) begin
      if (b == hist_byte) begin
        run_len = run_len + 8'd1;
        if (run_len == RUN_MAX || l) begin
          expect_code(run_len, l, 1'b0);
          count_byte();
          if (l) begin
            clear_message();
          end else begin
            counting   = 1'b0;
            run_len    = '0;
            hist_valid = 1'b0;
          end
        end
        return 1'b0;
      end
      // close the broken run, then take b as a fresh byte
      expect_code(run_len, 1'b0, 1'b0);
      count_byte();
      counting   = 1'b0;
      run_len    = '0;
      hist_valid = 1'b0;
    end
    if (out_count >= byte_limit) begin
      flag_overflow(l);
      return 1'b0;
    end
    if (hist_valid && b == hist_byte) begin
      expect_code(b, 1'b0, 1'b0);
      count_byte();
      if (out_count >= byte_limit) begin
        flag_overflow(l);
        return 1'b0;
      end
      if (l) begin
        expect_code(8'd0, 1'b1, 1'b0);
        clear_message();
      end else begin
        counting = 1'b1;
        run_len  = '0;
      end
      return 1'b0;
    end
    expect_code(b, l, 1'b0);
    count_byte();
    if (l) begin
      clear_message();
    end else begin
      hist_byte  = b;
      hist_valid = 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic l);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (!encode_byte(b, l)) begin
      useful_beats++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_codes.size() != 0);
    // let a beat that makes no result leave the pipeline
    repeat (DRAIN_HOLD) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    byte_limit = v;
  endtask

  task automatic send_message(input bit noisy);
    int         segs;
    int         reps;
    logic [7:0] base;
    logic [7:0] b;
    segs = $urandom_range(1, 10);
    base = 8'($urandom);
    for (int s = 0; s < segs; s++) begin
      if (noisy) begin
        b = 8'($urandom);
      end else begin
        b = base + 8'($urandom_range(0, 3));
      end
      case ($urandom_range(0, 199)) inside
        0:         reps = $urandom_range(250, 262);
        [1:40]:    reps = $urandom_range(2, 6);
        default:   reps = 1;
      endcase
      for (int r = 0; r < reps; r++) begin
        send_beat(b, (s == segs - 1) && (r == reps - 1));
      end
    end
  endtask

  task automatic test_literals_and_pairs();
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h12, 1'b0);
    send_beat(8'h12, 1'b0);
    send_beat(8'h34, 1'b1);
    repeat (4) send_beat(8'h07, 1'b0);
    send_beat(8'h07, 1'b1);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h55, 1'b1);
    repeat (3) send_beat(8'h3C, 1'b0);
    send_beat(8'hC3, 1'b1);
  endtask

  task automatic test_run_ceiling();
    // count saturates at 255, then a lone byte follows
    repeat (257) send_beat(8'h81, 1'b0);
    send_beat(8'h81, 1'b1);
    // new pair right after the 255 count, closed by a different last byte
    repeat (259) send_beat(8'h00, 1'b0);
    send_beat(8'h01, 1'b1);
  endtask

  task automatic test_overflow();
    set_limit(16'd0);
    send_beat(8'h11, 1'b0);
    send_beat(8'h22, 1'b0);
    send_beat(8'h33, 1'b1);
    send_beat(8'h44, 1'b1);
    set_limit(16'd1);
    send_beat(8'h11, 1'b0);
    send_beat(8'h22, 1'b1);
    send_beat(8'hAA, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'hAA, 1'b1);
    set_limit(16'd2);
    send_beat(8'h05, 1'b0);
    send_beat(8'h05, 1'b0);
    send_beat(8'h06, 1'b1);
    send_beat(8'h05, 1'b0);
    send_beat(8'h05, 1'b1);
    set_limit(16'd3);
    repeat (3) send_beat(8'h09, 1'b0);
    send_beat(8'h08, 1'b0);
    send_beat(8'h07, 1'b1);
    set_limit(LIMIT_RESET);
  endtask

  task automatic test_random_messages();
    int target;
    int msgs;
    target = useful_beats + RANDOM_BEATS;
    msgs   = 0;
    while (useful_beats < target) begin
      if (msgs % 6 == 0) begin
        case ($urandom_range(0, 5))
          0:       set_limit(16'($urandom_range(1, 4)));
          1, 2:    set_limit(16'($urandom_range(5, 40)));
          3:       set_limit(16'($urandom));
          4:       set_limit(LIMIT_RESET);
          default: set_limit(16'd1);
        endcase
      end else if ($urandom_range(0, 15) == 0) begin
        wait_drained();
      end
      send_message($urandom_range(0, 4) == 0);
      msgs++;
    end
  endtask

  task automatic test_full_limit();
    // fill the limit with literals back to back, then overflow and drop the rest
    set_limit(16'd48);
    for (int i = 0; i < 64; i++) begin
      send_beat(8'(i), i == 63);
    end
    set_limit(LIMIT_RESET);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result byte=%h last=%b overflow=%b",
                 $time, out_byte, out_last, overflow);
      end else begin
        want = pending_codes.pop_front();
        if (out_byte !== want.data) begin
          mismatches++;
          $display("%0t: out_byte expected %h got %h", $time, want.data, out_byte);
        end
        if (out_last !== want.last) begin
          mismatches++;
          $display("%0t: out_last expected %b got %b", $time, want.last, out_last);
        end
        if (overflow !== want.ovf) begin
          mismatches++;
          $display("%0t: overflow expected %b got %b", $time, want.ovf, overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    in_byte        = '0;
    in_last        = 1'b0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    byte_limit     = LIMIT_RESET;
    clear_message();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_literals_and_pairs();
    test_run_ceiling();
    test_overflow();
    test_random_messages();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_full_limit();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
